// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the complex arithmetic unit modules.
// Each macro expects signals named clk and rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/cau_pkg.sv =====
// Shared types, constants and helper functions for the complex arithmetic unit.
// No dependencies; every other RTL file but assert_macros.svh refers to this package by scoped name.
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // Operand width actually used, product width, quotient bits, root remainder width
  localparam int WB = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int PW = 2 * WB;
  localparam int QB = (WB > FRAC_BITS) ? WB : FRAC_BITS;
  localparam int RW = WB + 3;
  localparam int IO_W = 32;
  localparam int KIND_W = 3;
  localparam int Q_AW = 2;
  localparam int Q_DEPTH = 1 << Q_AW;

  // Operation codes on the kind port
  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MAG = 3'd4;
  localparam logic [KIND_W-1:0] KIND_EQ  = 3'd5;

  typedef logic signed [WB-1:0] word_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MAG,
    OP_EQ,
    OP_NONE
  } op_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    op_t   op;
    logic  eq;
    word_t ar;
    word_t ai;
    word_t br;
    word_t bi;
  } item_t;

  // One stage of the divide / square root pipeline
  typedef struct packed {
    logic            v;
    op_t             op;
    logic            eq;
    logic            dz;
    logic            ovf;
    word_t           rr;
    word_t           ri;
    logic            sn;
    logic            tn;
    logic            sbig;
    logic            tbig;
    logic [PW-1:0]   den;
    logic [PW-1:0]   rs;
    logic [PW-1:0]   rt;
    logic [QB-1:0]   ls;
    logic [QB-1:0]   lt;
    logic [QB-1:0]   qs;
    logic [QB-1:0]   qt;
    logic [RW-1:0]   rem;
    logic [WB-1:0]   root;
  } it_t;

  typedef struct packed {
    logic  ovf;
    word_t val;
  } sat_t;

  typedef struct packed {
    logic [PW-1:0] r;
    logic          qb;
  } dstep_t;

  // Clamp a sign and magnitude to the signed word range
  function automatic sat_t saturate(input logic neg, input logic [PW-1:0] mag);
    logic [PW-1:0] lim;
    logic [PW-1:0] m;
    logic [PW-1:0] twos;
    sat_t          r;
    lim = neg ? (PW'(1) << (WB - 1)) : ((PW'(1) << (WB - 1)) - PW'(1));
    r.ovf = mag > lim;
    m = r.ovf ? lim : mag;
    twos = PW'(0) - m;
    r.val = neg ? twos[WB-1:0] : m[WB-1:0];
    return r;
  endfunction

  // One restoring divide step: shift in a numerator bit, subtract if it fits
  function automatic dstep_t div_step(input logic [PW-1:0] r, input logic nb,
                                      input logic [PW-1:0] den);
    logic [PW:0] rsh;
    logic [PW:0] dif;
    dstep_t      o;
    rsh = {r, nb};
    dif = rsh - {1'b0, den};
    o.qb = rsh >= {1'b0, den};
    o.r = o.qb ? dif[PW-1:0] : rsh[PW-1:0];
    return o;
  endfunction

endpackage

// ===== hw/rtl/cau_front.sv =====
// Front end of the complex arithmetic unit: accepts items and classifies them.
// Depends on cau_pkg for the item type and operation codes.
module cau_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cau_pkg::KIND_W-1:0]   kind,
  input  logic signed [31:0]           a_real,
  input  logic signed [31:0]           a_imag,
  input  logic signed [31:0]           b_real,
  input  logic signed [31:0]           b_imag,
  output logic                         push_valid,
  input  logic                         push_ready,
  output cau_pkg::item_t               push_item
);

  localparam int WB = cau_pkg::WB;

  // Pass the handshake straight to the queue
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  // Decode the operation and take the low word bits of each operand
  always_comb begin
    unique case (kind)
      cau_pkg::KIND_ADD: push_item.op = cau_pkg::OP_ADD;
      cau_pkg::KIND_SUB: push_item.op = cau_pkg::OP_SUB;
      cau_pkg::KIND_MUL: push_item.op = cau_pkg::OP_MUL;
      cau_pkg::KIND_DIV: push_item.op = cau_pkg::OP_DIV;
      cau_pkg::KIND_MAG: push_item.op = cau_pkg::OP_MAG;
      cau_pkg::KIND_EQ:  push_item.op = cau_pkg::OP_EQ;
      default:           push_item.op = cau_pkg::OP_NONE;
    endcase
    push_item.ar = a_real[WB-1:0];
    push_item.ai = a_imag[WB-1:0];
    push_item.br = b_real[WB-1:0];
    push_item.bi = b_imag[WB-1:0];
    push_item.eq = (a_real[WB-1:0] == b_real[WB-1:0]) &&
                   (a_imag[WB-1:0] == b_imag[WB-1:0]);
  end

endmodule

// ===== hw/rtl/cau_queue.sv =====
// Short item queue between the front and the back of the arithmetic unit.
// Depends on cau_pkg for the item type and queue depth; uses assert_macros.svh.
`include "assert_macros.svh"

module cau_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  cau_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output cau_pkg::item_t pop_item
);

  localparam int AW = cau_pkg::Q_AW;
  localparam int DEPTH = cau_pkg::Q_DEPTH;

  cau_pkg::item_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           push_fire;
  logic           pop_fire;

  assign push_ready = count != (AW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) wr_ptr <= wr_ptr + 1'b1;
      if (pop_fire)  rd_ptr <= rd_ptr + 1'b1;
      if (push_fire && !pop_fire)      count <= count + 1'b1;
      else if (pop_fire && !push_fire) count <= count - 1'b1;
    end
  end

  // Store items
  always_ff @(posedge clk) begin
    if (push_fire) mem[wr_ptr] <= push_item;
  end

  `ASSERT_NEVER(a_q_over, count > (AW+1)'(DEPTH), "queue fill count beyond depth")
  `ASSERT_CLK(a_q_fill, (push_fire && !pop_fire) |=> (count == $past(count) + 1'b1), "queue count missed a push")

endmodule

// ===== hw/rtl/cau_back.sv =====
// Back end of the complex arithmetic unit: multipliers, sums, a bit-per-stage
// divide and square root pipeline, saturation and the output register.
// Depends on cau_pkg; uses assert_macros.svh.
`include "assert_macros.svh"

module cau_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  cau_pkg::item_t        pop_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    res_real,
  output logic signed [31:0]    res_imag,
  output logic                  is_equal,
  output logic                  divide_by_zero,
  output logic                  overflowed
);

  localparam int WB = cau_pkg::WB;
  localparam int PW = cau_pkg::PW;
  localparam int QB = cau_pkg::QB;
  localparam int RW = cau_pkg::RW;
  localparam int FRAC = cau_pkg::FRAC_BITS;
  localparam int IO_W = cau_pkg::IO_W;

  logic adv;

  // The whole pipeline moves when the output register can take an item
  assign adv = !out_valid || out_ready;
  assign pop_ready = adv;

  // Stage 1: products
  logic                   v1;
  cau_pkg::op_t           op1;
  logic                   eq1;
  cau_pkg::word_t         ar1, ai1, br1, bi1;
  logic signed [PW-1:0]   m0, m1, m2, m3, m4, m5;
  cau_pkg::word_t         sqa, sqb;

  // Square a for magnitude, b for the divisor
  always_comb begin
    sqa = (pop_item.op == cau_pkg::OP_MAG) ? pop_item.ar : pop_item.br;
    sqb = (pop_item.op == cau_pkg::OP_MAG) ? pop_item.ai : pop_item.bi;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= pop_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= pop_item.op;
      eq1 <= pop_item.eq;
      ar1 <= pop_item.ar;
      ai1 <= pop_item.ai;
      br1 <= pop_item.br;
      bi1 <= pop_item.bi;
      m0  <= pop_item.ar * pop_item.br;
      m1  <= pop_item.ai * pop_item.bi;
      m2  <= pop_item.ar * pop_item.bi;
      m3  <= pop_item.ai * pop_item.br;
      m4  <= sqa * sqa;
      m5  <= sqb * sqb;
    end
  end

  // Stage 2: exact sums as sign and magnitude, divisor energy
  logic                   v2;
  cau_pkg::op_t           op2;
  logic                   eq2;
  logic                   s_neg2, t_neg2;
  logic [PW-1:0]          s_mag2, t_mag2, den2;
  logic signed [PW:0]     sx, tx;
  logic [PW:0]            sa, ta;

  always_comb begin
    sx = '0;
    tx = '0;
    unique case (op1)
      cau_pkg::OP_ADD: begin
        sx = (PW+1)'(ar1) + (PW+1)'(br1);
        tx = (PW+1)'(ai1) + (PW+1)'(bi1);
      end
      cau_pkg::OP_SUB: begin
        sx = (PW+1)'(ar1) - (PW+1)'(br1);
        tx = (PW+1)'(ai1) - (PW+1)'(bi1);
      end
      cau_pkg::OP_MUL: begin
        sx = (PW+1)'(m0) - (PW+1)'(m1);
        tx = (PW+1)'(m2) + (PW+1)'(m3);
      end
      cau_pkg::OP_DIV: begin
        sx = (PW+1)'(m0) + (PW+1)'(m1);
        tx = (PW+1)'(m3) - (PW+1)'(m2);
      end
      default: ;
    endcase
    sa = sx[PW] ? $unsigned(-sx) : $unsigned(sx);
    ta = tx[PW] ? $unsigned(-tx) : $unsigned(tx);
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2    <= op1;
      eq2    <= eq1;
      s_neg2 <= sx[PW];
      t_neg2 <= tx[PW];
      s_mag2 <= sa[PW-1:0];
      t_mag2 <= ta[PW-1:0];
      den2   <= $unsigned(m4) + $unsigned(m5);
    end
  end

  // Stage 3: finish add, subtract and multiply; set up the divider
  cau_pkg::it_t stg [QB+1];
  cau_pkg::it_t nxt0;

  always_comb begin
    logic [PW+FRAC-1:0] nss;
    logic [PW+FRAC-1:0] nst;
    logic [PW-1:0]      ms;
    logic [PW-1:0]      mt;
    cau_pkg::sat_t      ss;
    cau_pkg::sat_t      st;
    nxt0 = '0;
    nxt0.v   = v2;
    nxt0.op  = op2;
    nxt0.eq  = eq2 && (op2 == cau_pkg::OP_EQ);
    nxt0.den = den2;
    nxt0.sn  = s_neg2;
    nxt0.tn  = t_neg2;
    nxt0.dz  = (op2 == cau_pkg::OP_DIV) && (den2 == '0);
    ms = (op2 == cau_pkg::OP_MUL) ? (s_mag2 >> FRAC) : s_mag2;
    mt = (op2 == cau_pkg::OP_MUL) ? (t_mag2 >> FRAC) : t_mag2;
    ss = cau_pkg::saturate(s_neg2, ms);
    st = cau_pkg::saturate(t_neg2, mt);
    if (op2 == cau_pkg::OP_ADD || op2 == cau_pkg::OP_SUB || op2 == cau_pkg::OP_MUL) begin
      nxt0.rr  = ss.val;
      nxt0.ri  = st.val;
      nxt0.ovf = ss.ovf || st.ovf;
    end
    // Quotient bits above QB only mean saturation
    nss = {s_mag2, {FRAC{1'b0}}};
    nst = {t_mag2, {FRAC{1'b0}}};
    nxt0.rs   = PW'(nss >> QB);
    nxt0.rt   = PW'(nst >> QB);
    nxt0.ls   = nss[QB-1:0];
    nxt0.lt   = nst[QB-1:0];
    nxt0.sbig = nxt0.rs >= den2;
    nxt0.tbig = nxt0.rt >= den2;
  end

  always_ff @(posedge clk) begin
    if (rst) stg[0].v <= 1'b0;
    else if (adv) stg[0] <= nxt0;
  end

  // One quotient bit per lane and one root bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_stage
    cau_pkg::it_t   cur;
    cau_pkg::it_t   nx;
    logic [RW-1:0]  sq_rem;
    logic [WB-1:0]  sq_root;

    assign cur = stg[k];

    if (k < WB) begin : g_root
      always_comb begin
        logic [RW-1:0] remx;
        logic [RW-1:0] trial;
        remx  = {cur.rem[RW-3:0], cur.den[PW-1-2*k -: 2]};
        trial = RW'({cur.root, 2'b01});
        if (remx >= trial) begin
          sq_rem  = remx - trial;
          sq_root = {cur.root[WB-2:0], 1'b1};
        end else begin
          sq_rem  = remx;
          sq_root = {cur.root[WB-2:0], 1'b0};
        end
      end
    end else begin : g_hold
      always_comb begin
        sq_rem  = cur.rem;
        sq_root = cur.root;
      end
    end

    always_comb begin
      cau_pkg::dstep_t ds;
      cau_pkg::dstep_t dt;
      ds = cau_pkg::div_step(cur.rs, cur.ls[QB-1], cur.den);
      dt = cau_pkg::div_step(cur.rt, cur.lt[QB-1], cur.den);
      nx = cur;
      nx.rs   = ds.r;
      nx.rt   = dt.r;
      nx.qs   = {cur.qs[QB-2:0], ds.qb};
      nx.qt   = {cur.qt[QB-2:0], dt.qb};
      nx.ls   = cur.ls << 1;
      nx.lt   = cur.lt << 1;
      nx.rem  = sq_rem;
      nx.root = sq_root;
    end

    always_ff @(posedge clk) begin
      if (rst) stg[k+1].v <= 1'b0;
      else if (adv) stg[k+1] <= nx;
    end
  end

  // Final: saturate quotient and root, pick the result
  cau_pkg::it_t   last;
  cau_pkg::word_t fin_rr, fin_ri;
  logic           fin_eq, fin_dz, fin_ovf;

  assign last = stg[QB];

  always_comb begin
    logic [PW-1:0] qr;
    logic [PW-1:0] qi;
    cau_pkg::sat_t sr;
    cau_pkg::sat_t si;
    cau_pkg::sat_t sq;
    qr = last.sbig ? (PW'(1) << QB) : PW'(last.qs);
    qi = last.tbig ? (PW'(1) << QB) : PW'(last.qt);
    sr = cau_pkg::saturate(last.sn, qr);
    si = cau_pkg::saturate(last.tn, qi);
    sq = cau_pkg::saturate(1'b0, PW'(last.root));
    fin_rr  = last.rr;
    fin_ri  = last.ri;
    fin_eq  = last.eq;
    fin_dz  = 1'b0;
    fin_ovf = last.ovf;
    if (last.op == cau_pkg::OP_DIV) begin
      if (last.dz) begin
        fin_rr  = '0;
        fin_ri  = '0;
        fin_dz  = 1'b1;
        fin_ovf = 1'b0;
      end else begin
        fin_rr  = sr.val;
        fin_ri  = si.val;
        fin_ovf = sr.ovf || si.ovf;
      end
    end else if (last.op == cau_pkg::OP_MAG) begin
      fin_rr  = sq.val;
      fin_ri  = '0;
      fin_ovf = sq.ovf;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= last.v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_real       <= IO_W'(fin_rr);
      res_imag       <= IO_W'(fin_ri);
      is_equal       <= fin_eq;
      divide_by_zero <= fin_dz;
      overflowed     <= fin_ovf;
    end
  end

  `ASSERT_CLK(a_dz_clean, (out_valid && divide_by_zero) |-> (!overflowed && !is_equal && res_real == '0 && res_imag == '0), "zero divisor result not clean")
  `ASSERT_NEVER(a_pop_stall, pop_ready && out_valid && !out_ready, "queue popped during output stall")

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit on signed Q16.16 operands: add, subtract, multiply,
// divide, magnitude and equality, one result per item. The unit takes one item
// per clock and returns one per clock when the output is not stalled. Items pass
// through the queue, product stage, sum stage, setup stage, 32 stages of the
// divide and square root pipeline (one quotient and one root bit each) and the
// output register. A four-item queue after the input lets items keep arriving
// while the output is stalled. Depends on cau_pkg, cau_front, cau_queue and
// cau_back.
module complex_arithmetic_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cau_pkg::KIND_W-1:0]  kind,
  input  logic signed [31:0]          a_real,
  input  logic signed [31:0]          a_imag,
  input  logic signed [31:0]          b_real,
  input  logic signed [31:0]          b_imag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          res_real,
  output logic signed [31:0]          res_imag,
  output logic                        is_equal,
  output logic                        divide_by_zero,
  output logic                        overflowed
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  cau_pkg::item_t push_item, pop_item;

  // Accept and classify
  cau_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .a_real     (a_real),
    .a_imag     (a_imag),
    .b_real     (b_real),
    .b_imag     (b_imag),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Decouple front and back
  cau_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Compute and deliver
  cau_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .res_real       (res_real),
    .res_imag       (res_imag),
    .is_equal       (is_equal),
    .divide_by_zero (divide_by_zero),
    .overflowed     (overflowed)
  );

endmodule
